@@ rtl/core/first_fit_arena_allocator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
// Property that must hold at every edge outside reset.
`define FFA_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("check failed");
// Implication into the next cycle, masked while reset is high.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");
// Implication into the next cycle, also checked across reset.
`define FFA_ASSERT_NEXT_RAW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("check failed");
`endif

@@ rtl/core/ffa_pkg.sv @@
// Package: constants, codes and types of the first-fit arena allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
   localparam int ADDR_W       = 12;
   localparam int CALC_W       = 18;
   localparam int POS_W        = 8;
   localparam int ARENA_BYTES  = 4096;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_BLOCKS_DEF = 64;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {OP_HOLD, OP_INSERT, OP_DELETE, OP_WRITE0} cell_op_type;
   typedef enum logic [1:0] {TOK_HOLD, TOK_LOAD, TOK_STEP} tok_op_type;
   typedef enum logic [1:0] {S_IDLE, S_ALLOC, S_FREE, S_DONE} state_type;

   typedef struct packed {
      cell_op_type        op;
      tok_op_type         tok;
      logic [POS_W-1:0]   pos;
      logic [ADDR_W-1:0]  start;
      logic [ADDR_W-1:0]  len;
   } cell_cmd_type;
endpackage
`default_nettype wire

@@ rtl/core/ffa_if.sv @@
// Interfaces: request and response channels of the allocator.
`timescale 1ns / 1ps
`default_nettype none
interface ffa_req_if import ffa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] request_bytes;
   logic [ADDR_W-1:0] release_address;
   modport source (output valid, kind, request_bytes, release_address, input ready);
   modport sink   (input valid, kind, request_bytes, release_address, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] payload_address;
   logic [1:0]        status;
   modport source (output valid, payload_address, status, input ready);
   modport sink   (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/first_fit_arena_allocator.sv @@
// Top level: first-fit arena allocator built from a chain of table cells.
// Operation: an allocate walks the table entries from the head until one fits
// or the last is reached; a free walks from entry 1 until the block is found,
// while a free of the head or on a table of at most one entry needs no walk.
// One transaction at a time; the token walk visits one chain entry per cycle.
// Reset: synchronous; empties the table and marks the head free, no sweep.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator import ffa_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ffa_req_if.sink   req_ch,
   ffa_rsp_if.source rsp_ch
);
   // per-cell views of the block table
   logic [ADDR_W-1:0] start_q [MAX_BLOCKS];
   logic [ADDR_W-1:0] len_q   [MAX_BLOCKS];
   logic              tok_q   [MAX_BLOCKS];
   logic [ADDR_W-1:0] cs_q    [MAX_BLOCKS];
   logic [ADDR_W-1:0] cl_q    [MAX_BLOCKS];
   logic [ADDR_W-1:0] ns_q    [MAX_BLOCKS];

   logic [ADDR_W-1:0] cur_start, cur_len, nxt_start;
   cell_cmd_type      cmd;

   // Build the chain: each cell shifts entries and the token with its neighbors.
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      logic [ADDR_W-1:0] l_start, l_len, r_start, r_len;
      logic              l_tok;
      if (g == 0) begin : g_first
         assign l_start = '0;
         assign l_len   = '0;
         assign l_tok   = 1'b0;
      end else begin : g_mid
         assign l_start = start_q[g-1];
         assign l_len   = len_q[g-1];
         assign l_tok   = tok_q[g-1];
      end
      if (g == MAX_BLOCKS - 1) begin : g_last
         assign r_start = '0;
         assign r_len   = '0;
      end else begin : g_inner
         assign r_start = start_q[g+1];
         assign r_len   = len_q[g+1];
      end
      ffa_cell #(.IDX(g)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_start  (l_start),
         .left_len    (l_len),
         .left_tok    (l_tok),
         .right_start (r_start),
         .right_len   (r_len),
         .start       (start_q[g]),
         .len         (len_q[g]),
         .tok         (tok_q[g]),
         .cur_start   (cs_q[g]),
         .cur_len     (cl_q[g]),
         .nxt_start   (ns_q[g])
      );
   end

   // Merge the one-hot gated cell outputs onto the shared read bus.
   always_comb begin
      cur_start = '0;
      cur_len   = '0;
      nxt_start = '0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         cur_start = cur_start | cs_q[k];
         cur_len   = cur_len | cl_q[k];
         nxt_start = nxt_start | ns_q[k];
      end
   end

   // Sequencer holds count, head flag and the response register.
   ffa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_kind   (req_ch.kind),
      .req_bytes  (req_ch.request_bytes),
      .req_addr   (req_ch.release_address),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_addr   (rsp_ch.payload_address),
      .rsp_status (rsp_ch.status),
      .cur_start  (cur_start),
      .cur_len    (cur_len),
      .nxt_start  (nxt_start),
      .cmd        (cmd)
   );
endmodule
`default_nettype wire

@@ rtl/core/ffa_cell.sv @@
// One table cell: a block entry plus the walk token, shifted with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module ffa_cell import ffa_pkg::*; #(
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_cmd_type      cmd,
   input  wire logic [ADDR_W-1:0] left_start,
   input  wire logic [ADDR_W-1:0] left_len,
   input  wire logic              left_tok,
   input  wire logic [ADDR_W-1:0] right_start,
   input  wire logic [ADDR_W-1:0] right_len,
   output logic [ADDR_W-1:0]      start,
   output logic [ADDR_W-1:0]      len,
   output logic                   tok,
   output logic [ADDR_W-1:0]      cur_start,
   output logic [ADDR_W-1:0]      cur_len,
   output logic [ADDR_W-1:0]      nxt_start
);
   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic [ADDR_W-1:0] start_ff, start_in, len_ff, len_in;
   logic              tok_ff, tok_in;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (MY_POS == cmd.pos) begin
               start_in = cmd.start;
               len_in   = cmd.len;
            end else if (MY_POS > cmd.pos) begin
               start_in = left_start;
               len_in   = left_len;
            end
         end
         OP_DELETE: begin
            if (MY_POS >= cmd.pos) begin
               start_in = right_start;
               len_in   = right_len;
            end
         end
         OP_WRITE0: begin
            if (MY_POS == '0) begin
               start_in = cmd.start;
               len_in   = cmd.len;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.tok)
         TOK_LOAD: tok_in = (MY_POS == cmd.pos);
         TOK_STEP: tok_in = left_tok;
         TOK_HOLD: tok_in = tok_ff;
         default:  tok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign start     = start_ff;
   assign len       = len_ff;
   assign tok       = tok_ff;
   assign cur_start = tok_ff ? start_ff : '0;
   assign cur_len   = tok_ff ? len_ff : '0;
   assign nxt_start = left_tok ? start_ff : '0;
endmodule
`default_nettype wire

@@ rtl/core/ffa_ctrl.sv @@
// Sequencer: accepts transactions, steps the token walk, issues cell commands.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl import ffa_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_kind,
   input  wire logic [ADDR_W-1:0] req_bytes,
   input  wire logic [ADDR_W-1:0] req_addr,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [ADDR_W-1:0]      rsp_addr,
   output logic [1:0]             rsp_status,
   input  wire logic [ADDR_W-1:0] cur_start,
   input  wire logic [ADDR_W-1:0] cur_len,
   input  wire logic [ADDR_W-1:0] nxt_start,
   output cell_cmd_type           cmd
);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CALC_W-1:0] HDR   = CALC_W'(HEADER_BYTES);
   localparam logic [CALC_W-1:0] ARENA = CALC_W'(ARENA_BYTES);

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in, idx_ff, idx_in;
   logic              head_free_ff, head_free_in;
   logic [ADDR_W-1:0] bytes_ff, bytes_in, addr_ff, addr_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;

   logic [CALC_W-1:0] need, used, nxt_w, used_hdr, acc_need;
   logic              free_head, has_next, last;

   assign need      = CALC_W'(bytes_ff) + HDR;
   assign acc_need  = CALC_W'(req_bytes) + HDR;
   assign free_head = (idx_ff == '0) && head_free_ff;
   assign used      = CALC_W'(cur_start) + HDR + (free_head ? '0 : CALC_W'(cur_len));
   assign used_hdr  = used + HDR;
   assign nxt_w     = CALC_W'(nxt_start);
   assign has_next  = (idx_ff + CW'(1)) < count_ff;
   assign last      = !has_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_free_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_free_ff <= head_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      bytes_ff    <= bytes_in;
      addr_ff     <= addr_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      head_free_in = head_free_ff;
      bytes_in     = bytes_ff;
      addr_in      = addr_ff;
      res_addr_in  = res_addr_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      req_ready    = 1'b0;
      cmd.op       = OP_HOLD;
      cmd.tok      = TOK_HOLD;
      cmd.pos      = '0;
      cmd.start    = '0;
      cmd.len      = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            res_addr_in = '0;
            if (req_valid) begin
               bytes_in = req_bytes;
               addr_in  = req_addr;
               idx_in   = '0;
               if (req_kind == KIND_ALLOC) begin
                  if (count_ff == '0 && acc_need + HDR >= ARENA) begin
                     res_st_in = ST_NO_SPACE;
                     state_in  = S_DONE;
                  end else begin
                     if (count_ff == '0) begin
                        // seed the free head entry at offset 0
                        cmd.op       = OP_WRITE0;
                        count_in     = CW'(1);
                        head_free_in = 1'b1;
                     end
                     cmd.tok  = TOK_LOAD;
                     state_in = S_ALLOC;
                  end
               end else if (CALC_W'(req_addr) == HDR) begin
                  head_free_in = 1'b1;
                  if (count_ff != '0) begin
                     cmd.op = OP_WRITE0;
                  end
                  res_st_in = ST_OK;
                  state_in  = S_DONE;
               end else if (count_ff <= CW'(1)) begin
                  res_st_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = CW'(1);
                  cmd.tok  = TOK_LOAD;
                  cmd.pos  = POS_W'(1);
                  state_in = S_FREE;
               end
            end
         end
         S_ALLOC: begin
            if (used + need >= ARENA) begin
               res_st_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else if (free_head && (last || nxt_w >= need)) begin
               cmd.op       = OP_WRITE0;
               cmd.len      = bytes_ff;
               head_free_in = 1'b0;
               res_addr_in  = ADDR_W'(HDR);
               res_st_in    = ST_OK;
               state_in     = S_DONE;
            end else if (!free_head && (last || (nxt_w > used && nxt_w - used >= need))) begin
               state_in = S_DONE;
               if (count_ff >= CW'(MAX_BLOCKS)) begin
                  res_st_in = ST_NO_SPACE;
               end else begin
                  cmd.op      = OP_INSERT;
                  cmd.pos     = POS_W'(idx_ff + CW'(1));
                  cmd.start   = ADDR_W'(used);
                  cmd.len     = bytes_ff;
                  count_in    = count_ff + CW'(1);
                  res_addr_in = ADDR_W'(used_hdr);
                  res_st_in   = ST_OK;
               end
            end else if (last) begin
               res_st_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               idx_in  = idx_ff + CW'(1);
               cmd.tok = TOK_STEP;
            end
         end
         S_FREE: begin
            if (CALC_W'(cur_start) + HDR == CALC_W'(addr_ff)) begin
               cmd.op    = OP_DELETE;
               cmd.pos   = POS_W'(idx_ff);
               count_in  = count_ff - CW'(1);
               res_st_in = ST_OK;
               state_in  = S_DONE;
            end else if (last) begin
               res_st_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in  = idx_ff + CW'(1);
               cmd.tok = TOK_STEP;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_st_ff;
endmodule
`default_nettype wire

@@ rtl/core/ffa_checker.sv @@
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_arena_allocator_defines.svh"
module ffa_checker import ffa_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ADDR_W-1:0] rsp_addr,
   input wire logic [1:0]        rsp_status
);
   `FFA_ASSERT_ALWAYS(a_status_code, !rsp_valid || rsp_status == ST_OK || rsp_status == ST_NO_SPACE || rsp_status == ST_NOT_FOUND)
   `FFA_ASSERT_ALWAYS(a_fail_addr_zero, !rsp_valid || rsp_status == ST_OK || rsp_addr == '0)
   `FFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_addr))
   `FFA_ASSERT_NEXT_RAW(a_reset_quiet, reset, !rsp_valid)
endmodule

bind first_fit_arena_allocator ffa_checker u_ffa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_addr   (rsp_ch.payload_address),
   .rsp_status (rsp_ch.status)
);
`default_nettype wire

@@ bench/first_fit_arena_allocator_tb.sv @@
// Testbench: random and directed allocate/free traffic checked against a table predictor.
`timescale 1ns / 1ps
`default_nettype none

import ffa_pkg::*;

// Scoreboard: keeps a shadow copy of the block table and the expected responses.
class arena_scoreboard;
   typedef struct {
      logic [ADDR_W-1:0] address;
      status_type        status;
   } grant_type;

   int unsigned blk_start[MAX_BLOCKS_DEF];
   int unsigned blk_len[MAX_BLOCKS_DEF];
   int unsigned blk_count;
   bit          head_free;
   grant_type   pending_grants[$];
   int          errors;
   int          n_ok, n_no_space, n_not_found, n_table_full;

   function new();
      blk_count = 0;
      head_free = 1;
      errors = 0;
   endfunction

   function automatic grant_type predict_alloc(int unsigned req);
      int unsigned need, used, cur, gap, k;
      bit          fh, has_next;
      grant_type   g;
      need = req + HEADER_BYTES;
      g.address = '0;
      g.status = ST_NO_SPACE;
      if (blk_count == 0) begin
         if (ARENA_BYTES - HEADER_BYTES <= need) return g;
         blk_start[0] = 0;
         blk_len[0] = 0;
         head_free = 1;
         blk_count = 1;
      end
      for (int unsigned i = 0; i < blk_count; i++) begin
         fh = (i == 0) && head_free;
         cur = fh ? 0 : blk_len[i];
         used = blk_start[i] + HEADER_BYTES + cur;
         has_next = (i + 1) < blk_count;
         if (used >= ARENA_BYTES || ARENA_BYTES - used <= need) return g;
         if (fh) begin
            gap = has_next ? blk_start[1] : need;
            if (gap >= need) begin
               blk_len[0] = req;
               head_free = 0;
               g.address = ADDR_W'(HEADER_BYTES);
               g.status = ST_OK;
               return g;
            end
         end else begin
            if (!has_next) gap = need;
            else gap = (blk_start[i+1] > used) ? blk_start[i+1] - used : 0;
            if (gap >= need) begin
               if (blk_count >= MAX_BLOCKS_DEF) begin
                  n_table_full++;
                  return g;
               end
               // shift the tail up by one and slot the new block in behind entry i
               for (k = blk_count; k > i + 1; k--) begin
                  blk_start[k] = blk_start[k-1];
                  blk_len[k] = blk_len[k-1];
               end
               blk_start[i+1] = used;
               blk_len[i+1] = req;
               blk_count++;
               g.address = ADDR_W'(used + HEADER_BYTES);
               g.status = ST_OK;
               return g;
            end
         end
      end
      return g;
   endfunction

   function automatic grant_type predict_free(int unsigned addr);
      grant_type g;
      g.address = '0;
      g.status = ST_OK;
      if (addr == HEADER_BYTES) begin
         head_free = 1;
         if (blk_count > 0) blk_len[0] = 0;
         return g;
      end
      for (int unsigned i = 1; i < blk_count; i++) begin
         if (blk_start[i] + HEADER_BYTES == addr) begin
            for (int unsigned k = i; k + 1 < blk_count; k++) begin
               blk_start[k] = blk_start[k+1];
               blk_len[k] = blk_len[k+1];
            end
            blk_count--;
            return g;
         end
      end
      g.status = ST_NOT_FOUND;
      return g;
   endfunction

   // Note an accepted request transaction and queue its expected response.
   function void note_request(logic kind, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] rel);
      grant_type g;
      if (kind == KIND_ALLOC) g = predict_alloc(req);
      else g = predict_free(rel);
      case (g.status)
         ST_OK:        n_ok++;
         ST_NO_SPACE:  n_no_space++;
         default:      n_not_found++;
      endcase
      pending_grants.push_back(g);
   endfunction

   // Check an accepted response transaction against the oldest expectation.
   function void check_response(logic [ADDR_W-1:0] addr, logic [1:0] st);
      grant_type g;
      if (pending_grants.size() == 0) begin
         $display("%0t: unexpected response address=%0d status=%0d", $time, addr, st);
         errors++;
         return;
      end
      g = pending_grants.pop_front();
      if (addr !== g.address) begin
         $display("%0t: payload_address expected %0d actual %0d", $time, g.address, addr);
         errors++;
      end
      if (st !== g.status) begin
         $display("%0t: status expected %0d actual %0d", $time, g.status, st);
         errors++;
      end
   endfunction

   // Payload address of a random live block, the head when the table is empty.
   function int unsigned live_address();
      int unsigned idx;
      if (blk_count <= 1) return HEADER_BYTES;
      idx = $urandom_range(0, blk_count - 1);
      return (idx == 0) ? HEADER_BYTES : blk_start[idx] + HEADER_BYTES;
   endfunction
endclass

module first_fit_arena_allocator_tb;
   import ffa_pkg::*;

   localparam int ITEMS      = 750;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   rx_hold = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   items_sent = 0;

   ffa_req_if req_ch ();
   ffa_rsp_if rsp_ch ();

   arena_scoreboard arena_sb;

   first_fit_arena_allocator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive every input to a known value from time zero.
   initial begin
      arena_sb = new();
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ALLOC;
      req_ch.request_bytes = '0;
      req_ch.release_address = '0;
      rsp_ch.ready = 1'b0;
   end

   // Monitor: sample both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            arena_sb.note_request(req_ch.kind, req_ch.request_bytes, req_ch.release_address);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            arena_sb.check_response(rsp_ch.payload_address, rsp_ch.status);
         end
      end
   end

   // Watchdog: count cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, no progress", $time);
            $display("first_fit_arena_allocator_tb NOT OK");
            $finish;
         end
      end
   end

   // Receiver: switch between stall patterns every so often; the pressure
   // process can force a long hold on top of that.
   int rx_mode = 0;
   int rx_mode_left = 0;
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_mode_left = $urandom_range(20, 200);
      end else begin
         rx_mode_left--;
      end
      if (reset || rx_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Pressure: hold off the receiver for a long stretch while requests keep coming.
   initial begin
      wait (!reset);
      repeat (800) @(posedge clock);
      rx_hold = 1;
      repeat (600) @(posedge clock);
      rx_hold = 0;
   end

   // Offer one request transaction and hold it until accepted. Between bursts
   // drop valid for a random gap.
   task automatic send_request(logic kind, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] rel);
      @(negedge clock);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.request_bytes <= req;
      req_ch.release_address <= rel;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic alloc_bytes(int unsigned n);
      send_request(KIND_ALLOC, n[ADDR_W-1:0], ADDR_W'($urandom));
   endtask

   task automatic free_at(int unsigned a);
      send_request(KIND_FREE, ADDR_W'($urandom), a[ADDR_W-1:0]);
   endtask

   int unsigned pick;
   int unsigned sz;

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: free of the head on an empty table, unknown address, room
      // check at the arena end, free head reuse, gaps and the full table.
      free_at(HEADER_BYTES);
      free_at(100);
      alloc_bytes(4095);
      alloc_bytes(4048);
      alloc_bytes(4047);
      free_at(HEADER_BYTES);
      free_at(HEADER_BYTES);
      alloc_bytes(0);
      alloc_bytes(100);
      alloc_bytes(200);
      free_at(HEADER_BYTES + 24);
      alloc_bytes(50);
      alloc_bytes(10);
      free_at(HEADER_BYTES);
      alloc_bytes(30);
      alloc_bytes(4000);
      free_at(4095);
      free_at(0);
      // Fill the table with empty blocks until it overflows.
      for (int i = 0; i < 66; i++) alloc_bytes(0);
      free_at(arena_sb.live_address());

      // Random: mostly live frees and modest allocations, some noise.
      while (items_sent < ITEMS) begin
         if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      sz = $urandom_range(0, 150);
            else if (pick < 9) sz = $urandom_range(0, 1000);
            else               sz = $urandom_range(0, 4095);
            alloc_bytes(sz);
         end else if ($urandom_range(0, 4) != 0) begin
            free_at(arena_sb.live_address());
         end else begin
            free_at($urandom_range(0, 4095));
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (arena_sb.pending_grants.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Covered %0d requests: %0d ok, %0d out of space (%0d with a full table),",
               items_sent, arena_sb.n_ok, arena_sb.n_no_space, arena_sb.n_table_full);
      $display("%0d unknown-address frees, under random sender gaps and receiver stalls.",
               arena_sb.n_not_found);
      if (arena_sb.errors == 0 && arena_sb.pending_grants.size() == 0) begin
         $display("first_fit_arena_allocator_tb OK");
      end else begin
         $display("first_fit_arena_allocator_tb NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
